### sv/two_link_arm_inverse_kinematics_macros.svh
// Assertion macros for the two-link arm IK block.
// Expects i_clk and i_rst_n in the scope of use.
`ifndef TWO_LINK_ARM_INVERSE_KINEMATICS_MACROS_SVH
`define TWO_LINK_ARM_INVERSE_KINEMATICS_MACROS_SVH

// same-cycle implication
`define TKIK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TKIK_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/tkik_pkg.sv
// Shared types, widths and constants of the two-link arm IK block.
// No dependencies.
package tkik_pkg;

    localparam int FRAC_BITS_DEF    = 8;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TAB_LEN          = 24;

    localparam int XW     = 24;  // io field width
    localparam int LW     = 23;  // link length width
    localparam int PW     = 25;  // offset-corrected position
    localparam int CFG_IW = 3;   // config index width
    localparam int NW     = 51;  // c2 numerator, signed
    localparam int MW     = 50;  // numerator magnitude
    localparam int DW     = 47;  // 2*L1*L2
    localparam int QF     = 30;  // cosine fraction bits
    localparam int C2W    = 32;  // signed Q30 cosine
    localparam int SMW    = 31;  // sine magnitude Q30
    localparam int SQW    = 62;  // square root datapath
    localparam int M1W    = 56;  // L2*c2
    localparam int M2W    = 54;  // L2*|s2|
    localparam int CW     = 60;  // CORDIC x/y datapath
    localparam int ZW     = 34;  // CORDIC angle, degrees Q24
    localparam int ANG_Q  = 24;

    localparam int DIV_STEPS  = 30;
    localparam int SQRT_STEPS = 31;

    localparam logic [LW-1:0]         L1_RST  = 23'd38400;
    localparam logic [LW-1:0]         L2_RST  = 23'd38400;
    localparam logic signed [C2W-1:0] C2_ONE  = 32'sd1073741824;
    localparam logic [SQW-1:0]        ONE_Q60 = 62'h1000_0000_0000_0000;
    localparam logic [SMW-1:0]        S2_MAX  = 31'd1073741824;
    localparam logic signed [ZW-1:0]  DEG180  = 34'sd3019898880;

    typedef enum logic [CFG_IW-1:0] {
        REG_L1   = 3'd0,
        REG_L2   = 3'd1,
        REG_OX   = 3'd2,
        REG_OY   = 3'd3,
        REG_MODE = 3'd4
    } t_reg_idx;

    typedef logic [31:0] t_atan;

    // atan(2^-i) in degrees Q24
    localparam t_atan ATAN_Q24 [TAB_LEN] = '{
        32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
        32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
        32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
        32'd234684,    32'd117342,    32'd58671,     32'd29335,
        32'd14668,     32'd7334,      32'd3667,      32'd1833,
        32'd917,       32'd458,       32'd229,       32'd115
    };

    // per-item context carried down the pipeline
    typedef struct packed {
        logic                  mode;
        logic                  oor;
        logic                  clamp;
        logic                  neg;
        logic signed [XW-1:0]  rx;
        logic signed [XW-1:0]  ry;
        logic signed [XW-1:0]  pz;
        logic signed [PW-1:0]  px;
        logic signed [PW-1:0]  py;
        logic [LW-1:0]         l1;
        logic [LW-1:0]         l2;
        logic signed [C2W-1:0] c2;
        logic [SMW-1:0]        s2m;
    } t_ctx;

endpackage

### sv/two_link_arm_inverse_kinematics.sv
// Top level of the two-link planar arm inverse kinematics block.
// Depends on tkik_pkg, tkik_cordic and two_link_arm_inverse_kinematics_macros.svh.
`include "two_link_arm_inverse_kinematics_macros.svh"

// Solves a Cartesian target (x, y, z) into shoulder and elbow angles of a
// two-link planar arm, negative elbow branch, fixed point with FRAC_BITS
// fraction bits (1/256 mm in, 1/256 degree out by default). The base offset
// is added to x and y first. A target beyond reach clamps the elbow cosine to
// +/-1 and sets out_of_reach; zero link lengths do the same. z passes through.
// With the pass-through mode register set, x and y come out unchanged as the
// joint angles.
// Throughput: one beat per cycle unless stalled, fully pipelined. The path
// from input beat to result runs through the 30-stage restoring cosine
// divider, the 31-stage square root and the three parallel CORDIC pipelines.
// A global pipeline enable stalls only when the last stage holds a result
// and the output register is still waiting to be taken; it then halts every
// stage and the input, even while bubbles remain. Configuration writes are
// always accepted and should be issued only while the pipeline is empty.
module two_link_arm_inverse_kinematics #(
    parameter int FRAC_BITS    = tkik_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = tkik_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tkik_pkg::CFG_IW-1:0]        i_cfg_index,
    input  logic [tkik_pkg::XW-1:0]            i_cfg_data,
    // target stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [3*tkik_pkg::XW-1:0]          s_axis_tdata,  // pos_x, pos_y, pos_z
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [3*tkik_pkg::XW-1:0]          m_axis_tdata,  // shoulder, elbow, height
    output logic                               m_axis_tuser   // out_of_reach
);
    import tkik_pkg::*;

    localparam int SH = ANG_Q - FRAC_BITS;      // Q24 -> output rounding shift
    localparam int KL = CORDIC_STEPS + 1;       // CORDIC latency
    localparam logic signed [ZW+1:0] RND    = (ZW+2)'(1) << (SH - 1);
    localparam logic signed [ZW+1:0] SAT_HI = (ZW+2)'(2**(XW-1) - 1);
    localparam logic signed [ZW+1:0] SAT_LO = -((ZW+2)'(2**(XW-1)));

    // Q24 angle -> output units, round half up, saturate
    function automatic logic signed [XW-1:0] f_to_out(input logic signed [ZW:0] v);
        logic signed [ZW+1:0] t;
        t = ($signed({v[ZW], v}) + RND) >>> SH;
        if (t > SAT_HI)
            return SAT_HI[XW-1:0];
        if (t < SAT_LO)
            return SAT_LO[XW-1:0];
        return t[XW-1:0];
    endfunction

    //------------------------------------------------------------------
    // configuration registers
    //------------------------------------------------------------------
    logic [LW-1:0]        r_l1, r_l2;
    logic signed [XW-1:0] r_ox, r_oy;
    logic                 r_mode;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1   <= L1_RST;
            r_l2   <= L2_RST;
            r_ox   <= '0;
            r_oy   <= '0;
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_L1:   r_l1   <= i_cfg_data[LW-1:0];
                REG_L2:   r_l2   <= i_cfg_data[LW-1:0];
                REG_OX:   r_ox   <= i_cfg_data;
                REG_OY:   r_oy   <= i_cfg_data;
                REG_MODE: r_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    //------------------------------------------------------------------
    // flow control
    //------------------------------------------------------------------
    logic w_en, w_out_load;
    logic r_fin_v, r_out_valid;

    // output register takes a beat when empty or being drained
    assign w_out_load    = !r_out_valid || m_axis_tready;
    // pipeline moves unless a finished result is stuck behind the output
    assign w_en          = !r_fin_v || w_out_load;
    assign s_axis_tready = w_en;

    //------------------------------------------------------------------
    // valid bits
    //------------------------------------------------------------------
    logic                  r_v1, r_v2, r_v3, r_v5, r_v6, r_v8, r_v10;
    logic [DIV_STEPS:0]    r_dv;
    logic [SQRT_STEPS:0]   r_sv;
    logic [KL:0]           r_kv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_dv        <= '0;
            r_v5        <= 1'b0;
            r_v6        <= 1'b0;
            r_sv        <= '0;
            r_v8        <= 1'b0;
            r_kv        <= '0;
            r_v10       <= 1'b0;
            r_fin_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_v1    <= s_axis_tvalid;
                r_v2    <= r_v1;
                r_v3    <= r_v2;
                r_dv    <= {r_dv[DIV_STEPS-1:0], r_v3};
                r_v5    <= r_dv[DIV_STEPS];
                r_v6    <= r_v5;
                r_sv    <= {r_sv[SQRT_STEPS-1:0], r_v6};
                r_v8    <= r_sv[SQRT_STEPS];
                r_kv    <= {r_kv[KL-1:0], r_v8};
                r_v10   <= r_kv[KL];
                r_fin_v <= r_v10;
            end
            if (w_out_load)
                r_out_valid <= r_fin_v;
        end
    end

    //------------------------------------------------------------------
    // stage 1: capture, add base offset
    //------------------------------------------------------------------
    t_ctx n_s1, r_s1, r_s2, r_s3;

    always_comb begin
        n_s1      = '0;
        n_s1.mode = r_mode;
        n_s1.rx   = s_axis_tdata[XW-1:0];
        n_s1.ry   = s_axis_tdata[2*XW-1:XW];
        n_s1.pz   = s_axis_tdata[3*XW-1:2*XW];
        n_s1.px   = PW'($signed(s_axis_tdata[XW-1:0])) + PW'(r_ox);
        n_s1.py   = PW'($signed(s_axis_tdata[2*XW-1:XW])) + PW'(r_oy);
        n_s1.l1   = r_l1;
        n_s1.l2   = r_l2;
    end

    // stage 2: squares and link product
    logic signed [2*PW-1:0] r_pxx, r_pyy;
    logic [2*LW-1:0]        r_l11, r_l22, r_l12;
    // stage 3: cosine numerator and denominator
    logic signed [NW-1:0]   r_num;
    logic [DW-1:0]          r_den;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1  <= n_s1;
            r_s2  <= r_s1;
            r_pxx <= r_s1.px * r_s1.px;
            r_pyy <= r_s1.py * r_s1.py;
            r_l11 <= r_s1.l1 * r_s1.l1;
            r_l22 <= r_s1.l2 * r_s1.l2;
            r_l12 <= r_s1.l1 * r_s1.l2;
            r_s3  <= r_s2;
            r_num <= NW'(r_pxx) + NW'(r_pyy) - $signed(NW'(r_l11)) - $signed(NW'(r_l22));
            r_den <= {r_l12, 1'b0};
        end
    end

    //------------------------------------------------------------------
    // stage 4: classify reach, then restoring divider, one bit a stage
    //------------------------------------------------------------------
    logic [MW-1:0] w_mag;
    t_ctx          n_s4;

    always_comb begin
        w_mag    = r_num[NW-1] ? MW'(-r_num) : MW'(r_num);
        n_s4     = r_s3;
        n_s4.neg = r_num[NW-1];
        if (r_den == '0) begin
            // zero link: cosine forced to +1
            n_s4.oor   = 1'b1;
            n_s4.clamp = 1'b1;
            n_s4.neg   = 1'b0;
        end else if (MW'(r_den) < w_mag) begin
            n_s4.oor   = 1'b1;
            n_s4.clamp = 1'b1;
        end else if (MW'(r_den) == w_mag) begin
            n_s4.clamp = 1'b1;
        end
    end

    t_ctx          r_dctx [0:DIV_STEPS];
    logic [DW-1:0] r_drem [0:DIV_STEPS];
    logic [DW-1:0] r_dden [0:DIV_STEPS];
    logic [QF-1:0] r_dq   [0:DIV_STEPS];
    logic [DW-1:0] n_drem [1:DIV_STEPS];
    logic [QF-1:0] n_dq   [1:DIV_STEPS];

    always_comb begin
        logic [DW:0]   r2;
        logic [DW+1:0] diff;
        for (int k = 1; k <= DIV_STEPS; k++) begin
            r2   = {r_drem[k-1], 1'b0};
            diff = {1'b0, r2} - {2'b00, r_dden[k-1]};
            if (!diff[DW+1]) begin
                n_drem[k] = diff[DW-1:0];
                n_dq[k]   = {r_dq[k-1][QF-2:0], 1'b1};
            end else begin
                n_drem[k] = r2[DW-1:0];
                n_dq[k]   = {r_dq[k-1][QF-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dctx[0] <= n_s4;
            r_drem[0] <= w_mag[DW-1:0];
            r_dden[0] <= r_den;
            r_dq[0]   <= '0;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                r_dctx[k] <= r_dctx[k-1];
                r_dden[k] <= r_dden[k-1];
                r_drem[k] <= n_drem[k];
                r_dq[k]   <= n_dq[k];
            end
        end
    end

    //------------------------------------------------------------------
    // stage 5: signed cosine; stage 6: its square
    //------------------------------------------------------------------
    t_ctx                    n_s5, r_s5, r_s6;
    logic signed [C2W-1:0]   w_q;
    logic signed [2*C2W-1:0] w_sq;
    logic [SQW-1:0]          r_sq;

    always_comb begin
        n_s5 = r_dctx[DIV_STEPS];
        w_q  = $signed(C2W'(r_dq[DIV_STEPS]));
        if (n_s5.clamp)
            n_s5.c2 = n_s5.neg ? -C2_ONE : C2_ONE;
        else
            n_s5.c2 = n_s5.neg ? -w_q : w_q;
    end

    assign w_sq = r_s5.c2 * r_s5.c2;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5 <= n_s5;
            r_s6 <= r_s5;
            r_sq <= SQW'(w_sq[SQW-2:0]);
        end
    end

    //------------------------------------------------------------------
    // integer square root of 1 - c2^2 (Q60), two bits a stage
    //------------------------------------------------------------------
    t_ctx           r_sctx [0:SQRT_STEPS];
    logic [SQW-1:0] r_srad [0:SQRT_STEPS];
    logic [SQW-1:0] r_sres [0:SQRT_STEPS];
    logic [SQW-1:0] n_srad [1:SQRT_STEPS];
    logic [SQW-1:0] n_sres [1:SQRT_STEPS];

    always_comb begin
        logic [SQW-1:0] bitv;
        logic [SQW-1:0] t;
        for (int k = 1; k <= SQRT_STEPS; k++) begin
            bitv = SQW'(1) << (2 * (SQRT_STEPS - k));
            t    = r_sres[k-1] + bitv;
            if (r_srad[k-1] >= t) begin
                n_srad[k] = r_srad[k-1] - t;
                n_sres[k] = (r_sres[k-1] >> 1) + bitv;
            end else begin
                n_srad[k] = r_srad[k-1];
                n_sres[k] = r_sres[k-1] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sctx[0] <= r_s6;
            r_srad[0] <= ONE_Q60 - r_sq;
            r_sres[0] <= '0;
            for (int k = 1; k <= SQRT_STEPS; k++) begin
                r_sctx[k] <= r_sctx[k-1];
                r_srad[k] <= n_srad[k];
                r_sres[k] <= n_sres[k];
            end
        end
    end

    //------------------------------------------------------------------
    // stage 8: L2 products; stage 9: CORDIC operands
    //------------------------------------------------------------------
    t_ctx                  n_s8, r_s8;
    logic signed [M1W-1:0] r_m1;
    logic [M2W-1:0]        r_m2;
    logic signed [CW-1:0]  r_y1, r_x1, r_y2, r_x2, r_y3, r_x3;
    t_ctx                  r_kctx [0:KL];

    always_comb begin
        n_s8     = r_sctx[SQRT_STEPS];
        n_s8.s2m = r_sres[SQRT_STEPS][SMW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s8      <= n_s8;
            r_m1      <= $signed({1'b0, n_s8.l2}) * n_s8.c2;
            r_m2      <= n_s8.l2 * n_s8.s2m;
            r_kctx[0] <= r_s8;
            r_y1      <= CW'(r_s8.py) <<< QF;
            r_x1      <= CW'(r_s8.px) <<< QF;
            r_y2      <= $signed(CW'(r_m2));
            r_x2      <= $signed(CW'(r_s8.l1) << QF) + CW'(r_m1);
            r_y3      <= $signed(CW'(r_s8.s2m) << ANG_Q);
            r_x3      <= CW'(r_s8.c2) <<< ANG_Q;
            for (int k = 1; k <= KL; k++)
                r_kctx[k] <= r_kctx[k-1];
        end
    end

    // target bearing, link-2 correction, elbow
    logic signed [ZW-1:0] w_z1, w_z2, w_z3;

    tkik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_tgt (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_y1),
        .i_x   (r_x1),
        .o_z   (w_z1)
    );

    tkik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_lnk (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_y2),
        .i_x   (r_x2),
        .o_z   (w_z2)
    );

    tkik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_elb (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_y   (r_y3),
        .i_x   (r_x3),
        .o_z   (w_z3)
    );

    //------------------------------------------------------------------
    // stage 10: combine angles; stage 11: round, saturate, mode mux
    //------------------------------------------------------------------
    t_ctx                 r_s10;
    logic signed [ZW:0]   r_sum, r_el;
    logic signed [XW-1:0] r_fin_sh, r_fin_el, r_fin_z;
    logic                 r_fin_oor;
    logic signed [XW-1:0] r_out_sh, r_out_el, r_out_z;
    logic                 r_out_oor;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s10     <= r_kctx[KL];
            r_sum     <= (ZW+1)'(w_z1) + (ZW+1)'(w_z2);
            r_el      <= -((ZW+1)'(w_z3));
            r_fin_sh  <= r_s10.mode ? r_s10.rx : f_to_out(r_sum);
            r_fin_el  <= r_s10.mode ? r_s10.ry : f_to_out(r_el);
            r_fin_z   <= r_s10.pz;
            r_fin_oor <= r_s10.mode ? 1'b0 : r_s10.oor;
        end
        if (w_out_load) begin
            r_out_sh  <= r_fin_sh;
            r_out_el  <= r_fin_el;
            r_out_z   <= r_fin_z;
            r_out_oor <= r_fin_oor;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_z, r_out_el, r_out_sh};
    assign m_axis_tuser  = r_out_oor;

    //------------------------------------------------------------------
    // assertions
    //------------------------------------------------------------------
    `TKIK_ASSERT_IMP(a_clamp_unit, r_v5 && r_s5.clamp, (r_s5.c2 == C2_ONE) || (r_s5.c2 == -C2_ONE), "clamped cosine is not +/-1")
    `TKIK_ASSERT_IMP(a_sine_range, r_v8, r_s8.s2m <= S2_MAX, "sine magnitude above one")
    `TKIK_ASSERT_IMP(a_oor_clamps, r_v10 && r_s10.oor, r_s10.clamp, "out of reach without clamp")
    `TKIK_ASSERT_IMP(a_stall_blocks, r_fin_v && r_out_valid && !m_axis_tready, !s_axis_tready, "input taken while pipeline is stalled")
    `TKIK_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, r_v1, "accepted beat did not enter the pipeline")

endmodule

### sv/tkik_cordic.sv
// Pipelined vectoring CORDIC, atan2(y, x) in degrees Q24.
// Depends on tkik_pkg. One item per cycle while i_en is high.
module tkik_cordic #(
    parameter int STEPS = tkik_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [tkik_pkg::CW-1:0] i_y,
    input  logic signed [tkik_pkg::CW-1:0] i_x,
    output logic signed [tkik_pkg::ZW-1:0] o_z
);
    import tkik_pkg::*;

    logic signed [CW-1:0] r_x [0:STEPS];
    logic signed [CW-1:0] r_y [0:STEPS];
    logic signed [ZW-1:0] r_z [0:STEPS];
    logic [STEPS:0]       r_hold;  // angle fixed by a y == 0 operand

    logic signed [CW-1:0] n_x [1:STEPS];
    logic signed [CW-1:0] n_y [1:STEPS];
    logic signed [ZW-1:0] n_z [1:STEPS];

    always_comb begin
        for (int i = 0; i < STEPS; i++) begin
            if (r_y[i] > 0) begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                n_z[i+1] = r_hold[i] ? r_z[i] : r_z[i] + ZW'(ATAN_Q24[i]);
            end else begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                n_z[i+1] = r_hold[i] ? r_z[i] : r_z[i] - ZW'(ATAN_Q24[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y == '0) begin
                r_hold[0] <= 1'b1;
                r_z[0]    <= (i_x < 0) ? DEG180 : '0;
                r_x[0]    <= i_x;
                r_y[0]    <= i_y;
            end else if (i_x < 0) begin
                // fold into the right half plane
                r_hold[0] <= 1'b0;
                r_z[0]    <= (i_y > 0) ? DEG180 : -DEG180;
                r_x[0]    <= -i_x;
                r_y[0]    <= -i_y;
            end else begin
                r_hold[0] <= 1'b0;
                r_z[0]    <= '0;
                r_x[0]    <= i_x;
                r_y[0]    <= i_y;
            end
            for (int i = 1; i <= STEPS; i++) begin
                r_x[i]    <= n_x[i];
                r_y[i]    <= n_y[i];
                r_z[i]    <= n_z[i];
                r_hold[i] <= r_hold[i-1];
            end
        end
    end

    assign o_z = r_z[STEPS];

endmodule
